FILE: src/sacl_pkg.sv
`default_nettype none

package sacl_pkg;

    // Associativity is 1, 2 or 4 ways; the way number is two bits wide.
    localparam int MAX_WAYS      = 4;
    localparam int MAX_WAYS_LOG2 = 2;
    localparam int WAY_W         = 2;
    localparam int CFG_W         = 2;
    localparam int SET_OUT_W     = 8;
    localparam int CNT_W         = 32;

    typedef logic [CNT_W-1:0] count_t;
    typedef logic [WAY_W-1:0] way_t;

    typedef struct packed {
        logic hit;
        way_t way;
    } lookup_t;

    // A request for more ways than the cache has is held to the maximum.
    function automatic logic [1:0] eff_log2(input logic [CFG_W-1:0] ways_log2);
        logic [1:0] lg;
        if (ways_log2 > CFG_W'(MAX_WAYS_LOG2))
        begin
            lg = 2'(MAX_WAYS_LOG2);
        end
        else
        begin
            lg = ways_log2;
        end
        return lg;
    endfunction

endpackage

`default_nettype wire

FILE: src/sacl_in_if.sv
`default_nettype none

interface sacl_in_if #(
    parameter int ADDR_WIDTH = 32
);
    logic                  valid;
    logic                  ready;
    logic [ADDR_WIDTH-1:0] address;

    modport source (output valid, output address, input ready);
    modport sink   (input valid, input address, output ready);
endinterface

`default_nettype wire

FILE: src/sacl_out_if.sv
`default_nettype none

interface sacl_out_if;
    import sacl_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 hit;
    way_t                 way_used;
    logic [SET_OUT_W-1:0] set_index;
    count_t               hit_total;
    count_t               miss_total;

    modport source (output valid, output hit, output way_used, output set_index,
                    output hit_total, output miss_total, input ready);
    modport sink   (input valid, input hit, input way_used, input set_index,
                    input hit_total, input miss_total, output ready);
endinterface

`default_nettype wire

FILE: src/sacl_row_ram.sv
`default_nettype none

module sacl_row_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: src/sacl_set_update.sv
`default_nettype none

module sacl_set_update
    import sacl_pkg::*;
#(
    parameter int ADDR_WIDTH = 32,
    parameter int AGE_WIDTH  = 16
) (
    input  wire logic [ADDR_WIDTH-1:0]                address,
    input  wire logic [1:0]                           ways_log2_eff,
    input  wire logic [1:0]                           offset,
    input  wire logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  tags_in,
    input  wire logic [MAX_WAYS-1:0][AGE_WIDTH-1:0]   ages_in,
    output lookup_t                                   result,
    output logic      [MAX_WAYS-1:0][ADDR_WIDTH-1:0]  tags_out,
    output logic      [MAX_WAYS-1:0][AGE_WIDTH-1:0]   ages_out
);

    localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

    logic [MAX_WAYS-1:0] in_set;
    logic                found;
    logic [1:0]          hit_bank;
    logic [1:0]          vic_bank;
    logic [1:0]          sel_bank;

    // The row holds MAX_WAYS lines; the set occupies the banks from offset on.
    always_comb
    begin
        logic [2:0] ways;
        logic [2:0] rel;
        ways = 3'd1 << ways_log2_eff;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            rel       = 3'(w) - {1'b0, offset};
            in_set[w] = (3'(w) >= {1'b0, offset}) && (rel < ways);
        end
    end

    // Banks are in way order, so the first match is the lowest way, and the
    // strict compare keeps the lowest way among equally old ones.
    always_comb
    begin
        found    = 1'b0;
        hit_bank = 2'd0;
        vic_bank = offset;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (!found && in_set[w] && (tags_in[w] == address))
            begin
                found    = 1'b1;
                hit_bank = 2'(w);
            end
            if (in_set[w] && (ages_in[w] > ages_in[vic_bank]))
            begin
                vic_bank = 2'(w);
            end
        end
        sel_bank   = found ? hit_bank : vic_bank;
        result.hit = found;
        result.way = sel_bank - offset;
    end

    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            tags_out[w] = tags_in[w];
            ages_out[w] = ages_in[w];
            if (in_set[w])
            begin
                if (2'(w) == sel_bank)
                begin
                    ages_out[w] = '0;
                    if (!found)
                    begin
                        tags_out[w] = address;
                    end
                end
                else if (ages_in[w] != AGE_MAX)
                begin
                    ages_out[w] = ages_in[w] + 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/set_assoc_cache_lru_lookup_unit.sv
// Set-associative cache lookup with least-recently-used replacement.
// Each beat on the lookup channel carries one address. The address picks a
// set (address modulo the number of sets), is compared with every way of that
// set, and either hits or replaces the oldest way. Each lookup gives exactly
// one beat on the result channel: hit, way, set and the running hit and miss
// totals including this lookup.
// Throughput is one lookup per cycle while the receiver takes results. The
// set's row is read from the tag and age RAMs at the accepting edge and written
// back as the lookup leaves the read stage; a lookup accepted while its row is
// being written takes the new row from a bypass register. An accepted beat is
// registered in the read stage, then in the result register that drives the
// result channel. After reset the block clears all TOTAL_LINES/4 RAM rows (64
// at the default size), one row a cycle; lookup.ready stays low meanwhile.
// cfg_wr_en and cfg_wr_data set ways_log2 and may be written only while idle.
// When the receiver stalls, the result register holds its beat, one lookup
// waits in the read stage, and then lookup.ready drops.
// TOTAL_LINES must be a power of two.
`default_nettype none

module set_assoc_cache_lru_lookup_unit
    import sacl_pkg::*;
#(
    parameter int TOTAL_LINES = 256,
    parameter int ADDR_WIDTH  = 32,
    parameter int AGE_WIDTH   = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data,
    sacl_in_if.sink         lookup,
    sacl_out_if.source      result
);

    localparam int SET_W  = $clog2(TOTAL_LINES);
    localparam int ROWS   = TOTAL_LINES / MAX_WAYS;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int TAG_RW = MAX_WAYS * ADDR_WIDTH;
    localparam int AGE_RW = MAX_WAYS * AGE_WIDTH;
    localparam logic [SET_W-1:0] SET_MASK = {SET_W{1'b1}};

    logic [CFG_W-1:0] ways_log2_reg;
    logic [1:0]       wl_eff;

    logic             clr_active_reg, clr_active_next;
    logic [ROW_W-1:0] clr_row_reg, clr_row_next;

    logic             s1_valid_reg, s1_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic             fwd_sel_reg, fwd_sel_next;
    count_t           hit_cnt_reg, hit_cnt_next;
    count_t           miss_cnt_reg, miss_cnt_next;

    logic [ADDR_WIDTH-1:0] s1_addr_reg;
    logic [SET_W-1:0]      s1_set_reg;
    logic [ROW_W-1:0]      s1_row_reg;
    logic [1:0]            s1_off_reg;

    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] fwd_tags_reg;
    logic [MAX_WAYS-1:0][AGE_WIDTH-1:0]  fwd_ages_reg;

    logic                 res_hit_reg;
    way_t                 res_way_reg;
    logic [SET_OUT_W-1:0] res_set_reg;
    count_t               res_hit_total_reg;
    count_t               res_miss_total_reg;

    logic [ADDR_WIDTH+SET_W-1:0] in_addr_ext;
    logic [SET_W-1:0]            in_set;
    logic [SET_W-1:0]            in_base;
    logic [ROW_W-1:0]            in_row;

    logic accept;
    logic out_free;
    logic s1_done;

    logic [TAG_RW-1:0] rd_tags;
    logic [AGE_RW-1:0] rd_ages;
    logic [TAG_RW-1:0] wr_tags;
    logic [AGE_RW-1:0] wr_ages;
    logic              wr_en;
    logic [ROW_W-1:0]  wr_row;

    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] cur_tags, new_tags;
    logic [MAX_WAYS-1:0][AGE_WIDTH-1:0]  cur_ages, new_ages;
    lookup_t                             upd;
    logic [SET_W+SET_OUT_W-1:0]          set_ext;

    assign wl_eff = eff_log2(ways_log2_reg);

    // Line (set * ways + way) lives in row line/4, bank line%4.
    assign in_addr_ext = {{SET_W{1'b0}}, lookup.address};
    assign in_set      = in_addr_ext[SET_W-1:0] & (SET_MASK >> wl_eff);
    assign in_base     = in_set << wl_eff;
    assign in_row      = in_base[SET_W-1:2];

    assign out_free     = !out_valid_reg || result.ready;
    assign s1_done      = s1_valid_reg && out_free;
    assign lookup.ready = !clr_active_reg && (!s1_valid_reg || out_free);
    assign accept       = lookup.valid && lookup.ready;

    assign cur_tags = fwd_sel_reg ? fwd_tags_reg : rd_tags;
    assign cur_ages = fwd_sel_reg ? fwd_ages_reg : rd_ages;

    sacl_set_update #(
        .ADDR_WIDTH (ADDR_WIDTH),
        .AGE_WIDTH  (AGE_WIDTH)
    ) u_update (
        .address       (s1_addr_reg),
        .ways_log2_eff (wl_eff),
        .offset        (s1_off_reg),
        .tags_in       (cur_tags),
        .ages_in       (cur_ages),
        .result        (upd),
        .tags_out      (new_tags),
        .ages_out      (new_ages)
    );

    assign wr_en   = clr_active_reg || s1_done;
    assign wr_row  = clr_active_reg ? clr_row_reg : s1_row_reg;
    assign wr_tags = clr_active_reg ? '0 : new_tags;
    assign wr_ages = clr_active_reg ? '0 : new_ages;

    sacl_row_ram #(
        .WIDTH (TAG_RW),
        .DEPTH (ROWS)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_row),
        .wr_data (wr_tags),
        .rd_en   (accept),
        .rd_addr (in_row),
        .rd_data (rd_tags)
    );

    sacl_row_ram #(
        .WIDTH (AGE_RW),
        .DEPTH (ROWS)
    ) u_age_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_row),
        .wr_data (wr_ages),
        .rd_en   (accept),
        .rd_addr (in_row),
        .rd_data (rd_ages)
    );

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_row_next    = clr_row_reg;
        if (clr_active_reg)
        begin
            clr_row_next = clr_row_reg + 1'b1;
            if (clr_row_reg == ROW_W'(ROWS - 1))
            begin
                clr_active_next = 1'b0;
            end
        end

        s1_valid_next = accept ? 1'b1 : (s1_done ? 1'b0 : s1_valid_reg);
        // A lookup read at the same edge its row is written sees stale data.
        fwd_sel_next  = accept ? (s1_done && (in_row == s1_row_reg)) : fwd_sel_reg;

        out_valid_next = s1_done ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (s1_done)
        begin
            if (upd.hit)
            begin
                if (hit_cnt_reg != '1)
                begin
                    hit_cnt_next = hit_cnt_reg + 1'b1;
                end
            end
            else if (miss_cnt_reg != '1)
            begin
                miss_cnt_next = miss_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_log2_reg  <= '0;
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_sel_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ways_log2_reg <= cfg_wr_data;
            end
            clr_active_reg <= clr_active_next;
            clr_row_reg    <= clr_row_next;
            s1_valid_reg   <= s1_valid_next;
            fwd_sel_reg    <= fwd_sel_next;
            out_valid_reg  <= out_valid_next;
            hit_cnt_reg    <= hit_cnt_next;
            miss_cnt_reg   <= miss_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg  <= lookup.address;
            s1_set_reg   <= in_set;
            s1_row_reg   <= in_row;
            s1_off_reg   <= in_base[1:0];
            fwd_tags_reg <= new_tags;
            fwd_ages_reg <= new_ages;
        end
    end

    assign set_ext = {{SET_OUT_W{1'b0}}, s1_set_reg};

    always_ff @(posedge clk)
    begin
        if (s1_done)
        begin
            res_hit_reg        <= upd.hit;
            res_way_reg        <= upd.way;
            res_set_reg        <= set_ext[SET_OUT_W-1:0];
            res_hit_total_reg  <= hit_cnt_next;
            res_miss_total_reg <= miss_cnt_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.hit        = res_hit_reg;
    assign result.way_used   = res_way_reg;
    assign result.set_index  = res_set_reg;
    assign result.hit_total  = res_hit_total_reg;
    assign result.miss_total = res_miss_total_reg;

endmodule

`default_nettype wire
